FILE: hw/rtl/l2_loss_with_gradient_macros.svh
// Assertion macros for the L2 loss block.
// Included by the top level; expects signals clk and rst in the including scope.
`ifndef L2_LOSS_WITH_GRADIENT_MACROS_SVH
`define L2_LOSS_WITH_GRADIENT_MACROS_SVH

`ifndef SYNTH
`define L2LG_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define L2LG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define L2LG_ASSERT_IMPLY(lbl, ante, cons, msg)
`define L2LG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/l2lg_pkg.sv
// Shared widths, register codes and queue entry type of the L2 loss block.
// No dependencies.
package l2lg_pkg;
  localparam int DATA_W    = 16;
  localparam int GRAD_W    = 17;
  localparam int MAG_W     = 16;
  localparam int HSQ_W     = 31;
  localparam int LOSS_W    = 44;
  localparam int BSUM_W    = 52;
  localparam int SSIZE_W   = 13;
  localparam int BSIZE_W   = 9;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE  = 1'b1;

  localparam logic [LOSS_W-1:0] LOSS_MAX = '1;
  localparam logic [BSUM_W-1:0] BSUM_MAX = '1;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gradient;
    logic                     sample_end;
    logic                     batch_end;
  } l2lg_entry_t;
endpackage

FILE: hw/rtl/l2lg_ifs.sv
// Valid/ready channel interfaces for the element stream and the result stream.
// Depends on l2lg_pkg.
interface l2lg_item_if;
  import l2lg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] predicted;
  logic signed [DATA_W-1:0] target;
  modport source(output valid, output predicted, output target, input ready);
  modport sink(input valid, input predicted, input target, output ready);
endinterface

interface l2lg_result_if;
  import l2lg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [GRAD_W-1:0] gradient;
  logic                     sample_end;
  logic [LOSS_W-1:0]        sample_loss;
  logic                     batch_end;
  logic [LOSS_W-1:0]        mean_loss;
  modport source(output valid, output gradient, output sample_end, output sample_loss,
                 output batch_end, output mean_loss, input ready);
  modport sink(input valid, input gradient, input sample_end, input sample_loss,
               input batch_end, input mean_loss, output ready);
endinterface

FILE: hw/rtl/l2lg_fifo.sv
// Short register queue between the front and back parts.
// Depends on l2lg_pkg.
module l2lg_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  l2lg_pkg::l2lg_entry_t push_data,
  input  logic                  pop,
  output l2lg_pkg::l2lg_entry_t head,
  output logic                  full,
  output logic                  empty
);
  import l2lg_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  l2lg_entry_t   slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end
endmodule

FILE: hw/rtl/l2lg_front.sv
// Front part: accepts elements, forms the gradient and marks sample and batch ends.
// Depends on l2lg_pkg and l2lg_item_if.
module l2lg_front #(
  parameter int MAX_SAMPLE_ELEMENTS = 4096,
  parameter int MAX_BATCH           = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [l2lg_pkg::SSIZE_W-1:0]        sample_size,
  input  logic [l2lg_pkg::BSIZE_W-1:0]        batch_size,
  l2lg_item_if.sink                           item,
  input  logic                                full,
  output logic                                push,
  output l2lg_pkg::l2lg_entry_t               entry,
  output logic [$clog2(MAX_BATCH + 1)-1:0]    divisor
);
  import l2lg_pkg::*;

  localparam int ECW   = $clog2(MAX_SAMPLE_ELEMENTS + 1);
  localparam int BCW   = $clog2(MAX_BATCH + 1);
  localparam int SCMPW = (ECW > SSIZE_W) ? ECW : SSIZE_W;
  localparam int BCMPW = (BCW > BSIZE_W) ? BCW : BSIZE_W;

  logic [ECW-1:0]   element_count;
  logic [ECW-1:0]   ec_inc;
  logic [BCW-1:0]   sample_count;
  logic [BCW-1:0]   sc_inc;
  logic [SCMPW-1:0] ss_ext;
  logic [SCMPW-1:0] eff_s;
  logic [BCMPW-1:0] bs_ext;
  logic [BCMPW-1:0] eff_b;
  logic             s_end;
  logic             b_end;

  // Clamp sizes: zero acts as one, oversize acts as the maximum.
  assign ss_ext = SCMPW'(sample_size);
  assign bs_ext = BCMPW'(batch_size);

  always_comb begin
    priority if (ss_ext == '0) begin
      eff_s = SCMPW'(1);
    end else if (ss_ext > SCMPW'(MAX_SAMPLE_ELEMENTS)) begin
      eff_s = SCMPW'(MAX_SAMPLE_ELEMENTS);
    end else begin
      eff_s = ss_ext;
    end
  end

  always_comb begin
    priority if (bs_ext == '0) begin
      eff_b = BCMPW'(1);
    end else if (bs_ext > BCMPW'(MAX_BATCH)) begin
      eff_b = BCMPW'(MAX_BATCH);
    end else begin
      eff_b = bs_ext;
    end
  end

  assign divisor = BCW'(eff_b);

  assign ec_inc = element_count + 1'b1;
  assign sc_inc = sample_count + 1'b1;
  assign s_end  = (SCMPW'(ec_inc) >= eff_s);
  assign b_end  = s_end && (BCMPW'(sc_inc) >= eff_b);

  assign item.ready = !full;
  assign push       = item.valid && !full;

  assign entry.gradient   = $signed(GRAD_W'(item.predicted)) - $signed(GRAD_W'(item.target));
  assign entry.sample_end = s_end;
  assign entry.batch_end  = b_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
      sample_count  <= '0;
    end else if (push) begin
      element_count <= s_end ? '0 : ec_inc;
      if (b_end) begin
        sample_count <= '0;
      end else if (s_end) begin
        sample_count <= sc_inc;
      end
    end
  end
endmodule

FILE: hw/rtl/l2lg_div.sv
// Restoring divider, one quotient bit per cycle, for the batch mean.
// Depends on l2lg_pkg.
module l2lg_div #(
  parameter int DVW = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [l2lg_pkg::BSUM_W-1:0]  dividend,
  input  logic [DVW-1:0]               divisor,
  output logic                         busy,
  output logic [l2lg_pkg::BSUM_W-1:0]  quotient
);
  import l2lg_pkg::*;

  localparam int CNT_W = $clog2(BSUM_W + 1);

  logic [DVW-1:0]   rem;
  logic [CNT_W-1:0] cnt;
  logic [DVW:0]     trial;
  logic [DVW:0]     diff;
  logic             ge;

  assign trial = {rem, quotient[BSUM_W-1]};
  assign ge    = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[BSUM_W-2:0], ge};
      rem      <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(BSUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

FILE: hw/rtl/l2lg_back.sv
// Back part: squares, accumulates sample and batch sums, launches the mean division.
// Depends on l2lg_pkg and l2lg_result_if.
module l2lg_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         empty,
  input  l2lg_pkg::l2lg_entry_t        head,
  output logic                         pop,
  output logic                         div_start,
  output logic [l2lg_pkg::BSUM_W-1:0]  div_dividend,
  input  logic                         div_busy,
  input  logic [l2lg_pkg::BSUM_W-1:0]  div_quot,
  l2lg_result_if.source                result
);
  import l2lg_pkg::*;

  // square stage
  logic                     s1_valid;
  logic signed [GRAD_W-1:0] s1_grad;
  logic [HSQ_W-1:0]         s1_hsq;
  logic                     s1_send;
  logic                     s1_bend;
  // accumulate stage
  logic                     s2_valid;
  logic signed [GRAD_W-1:0] s2_grad;
  logic [LOSS_W-1:0]        s2_sloss;
  logic                     s2_send;
  logic                     s2_bend;
  logic                     s2_div;
  // accumulators
  logic [LOSS_W-1:0]        sample_sum;
  logic [BSUM_W-1:0]        batch_sum;

  logic signed [GRAD_W-1:0] abs_d;
  logic [MAG_W-1:0]         mag;
  logic [2*MAG_W-1:0]       sq;
  logic [LOSS_W:0]          sum_wide;
  logic [LOSS_W-1:0]        sum_sat;
  logic [BSUM_W:0]          bsum_wide;
  logic [BSUM_W-1:0]        bsum_sat;
  logic [LOSS_W-1:0]        mean_sat;
  logic                     out_free;
  logic                     s2_leave;
  logic                     s2_free;
  logic                     s1_move;

  assign abs_d = head.gradient[GRAD_W-1] ? -head.gradient : head.gradient;
  assign mag   = abs_d[MAG_W-1:0];
  assign sq    = (2*MAG_W)'(mag) * (2*MAG_W)'(mag);

  assign sum_wide = {1'b0, sample_sum} + (LOSS_W + 1)'(s1_hsq);
  assign sum_sat  = sum_wide[LOSS_W] ? LOSS_MAX : sum_wide[LOSS_W-1:0];

  assign bsum_wide = {1'b0, batch_sum} + (BSUM_W + 1)'(s2_sloss);
  assign bsum_sat  = bsum_wide[BSUM_W] ? BSUM_MAX : bsum_wide[BSUM_W-1:0];

  assign mean_sat = (|div_quot[BSUM_W-1:LOSS_W]) ? LOSS_MAX : div_quot[LOSS_W-1:0];

  assign out_free  = !result.valid || result.ready;
  assign s2_leave  = s2_valid && out_free && (!s2_bend || (s2_div && !div_busy));
  assign s2_free   = !s2_valid || s2_leave;
  assign s1_move   = s1_valid && s2_free;
  assign pop       = !empty && (!s1_valid || s1_move);
  assign div_start = s2_valid && s2_bend && !s2_div;
  assign div_dividend = bsum_sat;

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_grad <= head.gradient;
      s1_hsq  <= sq[2*MAG_W-1:1];
      s1_send <= head.sample_end;
      s1_bend <= head.batch_end;
    end
    if (s1_move) begin
      s2_grad  <= s1_grad;
      s2_send  <= s1_send;
      s2_bend  <= s1_bend;
      s2_sloss <= s1_send ? sum_sat : '0;
    end
    if (s2_leave) begin
      result.gradient    <= s2_grad;
      result.sample_end  <= s2_send;
      result.sample_loss <= s2_sloss;
      result.batch_end   <= s2_bend;
      result.mean_loss   <= s2_bend ? mean_sat : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s2_div       <= 1'b0;
      result.valid <= 1'b0;
      sample_sum   <= '0;
      batch_sum    <= '0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end

      if (s1_move) begin
        s2_valid   <= 1'b1;
        sample_sum <= s1_send ? '0 : sum_sat;
      end else if (s2_leave) begin
        s2_valid <= 1'b0;
      end

      // batch total: fold in at sample end, hand to the divider at batch end
      if (div_start) begin
        s2_div    <= 1'b1;
        batch_sum <= '0;
      end else if (s2_leave) begin
        s2_div <= 1'b0;
        if (s2_send && !s2_bend) begin
          batch_sum <= bsum_sat;
        end
      end

      if (s2_leave) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end
endmodule

FILE: hw/rtl/l2_loss_with_gradient.sv
// Path: an element passes through the queue, the square stage, the accumulate stage
//   and result register; a batch end waits on the 52-step bit-serial mean divider.
// Throughput: one element per cycle between batch ends unless the output stalls;
//   a batch end holds the back part for the division, and the 4-entry queue plus
//   the square stage take up to five more elements before ready drops.
// Reset (rst, synchronous): sizes return to 1, counters and sums clear, queue empties.
`include "l2_loss_with_gradient_macros.svh"

module l2_loss_with_gradient #(
  parameter int MAX_SAMPLE_ELEMENTS = 4096,
  parameter int MAX_BATCH           = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [l2lg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [l2lg_pkg::CFG_W-1:0]      cfg_data,
  l2lg_item_if.sink                       item,
  l2lg_result_if.source                   result
);
  import l2lg_pkg::*;

  localparam int BCW = $clog2(MAX_BATCH + 1);

  // configuration registers
  logic [SSIZE_W-1:0] sample_size;
  logic [BSIZE_W-1:0] batch_size;

  // front to queue
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  l2lg_entry_t        q_in;
  l2lg_entry_t        q_head;

  // back to divider
  logic [BCW-1:0]     divisor;
  logic               div_start;
  logic               div_busy;
  logic [BSUM_W-1:0]  div_dividend;
  logic [BSUM_W-1:0]  div_quot;

  // Configuration writes land directly; the user must write while idle (unchecked).
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_size <= SSIZE_W'(1);
      batch_size  <= BSIZE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_SIZE: sample_size <= cfg_data[SSIZE_W-1:0];
        REG_BATCH_SIZE:  batch_size  <= cfg_data[BSIZE_W-1:0];
        default:         sample_size <= sample_size;
      endcase
    end
  end

  // Front: take one element per transfer, compute the gradient, tag the ends.
  l2lg_front #(
    .MAX_SAMPLE_ELEMENTS(MAX_SAMPLE_ELEMENTS),
    .MAX_BATCH(MAX_BATCH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .sample_size(sample_size),
    .batch_size(batch_size),
    .item(item),
    .full(q_full),
    .push(q_push),
    .entry(q_in),
    .divisor(divisor)
  );

  // Queue: decouple the front from a back part stalled on division or output.
  l2lg_fifo #(
    .DEPTH(4)
  ) u_fifo (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data(q_in),
    .pop(q_pop),
    .head(q_head),
    .full(q_full),
    .empty(q_empty)
  );

  // Back: square, accumulate with saturation, drive the result register.
  l2lg_back u_back (
    .clk(clk),
    .rst(rst),
    .empty(q_empty),
    .head(q_head),
    .pop(q_pop),
    .div_start(div_start),
    .div_dividend(div_dividend),
    .div_busy(div_busy),
    .div_quot(div_quot),
    .result(result)
  );

  // Mean divider: batch total over effective batch size.
  l2lg_div #(
    .DVW(BCW)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .dividend(div_dividend),
    .divisor(divisor),
    .busy(div_busy),
    .quotient(div_quot)
  );

  `L2LG_ASSERT_IMPLY(a_batch_in_sample, result.valid && result.batch_end, result.sample_end, "batch end outside sample end")
  `L2LG_ASSERT_IMPLY(a_loss_only_at_end, result.valid && !result.sample_end, result.sample_loss == '0, "sample loss off sample end")
  `L2LG_ASSERT_IMPLY(a_div_idle_start, div_start, !div_busy, "divider started while busy")
  `L2LG_ASSERT_NEXT(a_div_runs, div_start, div_busy, "divider failed to run")
endmodule
